// ----- rtl/c16d_pkg.sv -----
// Shared types, constants and CRC functions for the CRC-16 serial deframer.
// No dependencies; used by c16d_front, c16d_queue and crc16_serial_deframer_top.
`timescale 1ns / 1ps

package c16d_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned WindowLen  = 8;
  localparam int unsigned FrameBytes = 9;
  localparam int unsigned CountW     = 4;
  localparam int unsigned CfgIdxW    = 2;

  localparam logic [15:0] CrcPoly = 16'hA001;
  localparam logic [15:0] CrcInit = 16'hFFFF;

  localparam logic [ByteW-1:0] HeaderReset = 8'hDD;
  localparam logic [ByteW-1:0] TailReset   = 8'hED;

  localparam logic [CountW-1:0] FreshFull = 4'd9;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HEADER = 2'd0,
    CFG_TAIL   = 2'd1
  } cfg_idx_e;

  typedef logic [WindowLen-1:0][ByteW-1:0] window_t;

  typedef struct packed {
    logic [ByteW-1:0] first;
    logic [ByteW-1:0] second;
    logic [ByteW-1:0] third;
    logic [ByteW-1:0] fourth;
  } payload_t;

  typedef struct packed {
    logic                 valid;
    logic [CfgIdxW-1:0]   index;
    logic [ByteW-1:0]     data;
  } cfg_wr_t;

  // One byte of the reflected Modbus CRC, processed LSB first.
  function automatic logic [15:0] crc_feed(logic [15:0] crc_in, logic [ByteW-1:0] b);
    logic [15:0] crc;
    crc = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CrcPoly;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

  // True when the CRC over all window bytes, oldest first, leaves a zero remainder.
  function automatic logic window_crc_zero(window_t w);
    logic [15:0] crc;
    crc = CrcInit;
    for (int i = 0; i < WindowLen; i++) begin
      crc = crc_feed(crc, w[i]);
    end
    return (crc == 16'h0000);
  endfunction

endpackage

// ----- rtl/c16d_front.sv -----
// Front end of the deframer: configuration registers, byte window, fresh count
// and frame classification. Depends on c16d_pkg.
`timescale 1ns / 1ps

module c16d_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  c16d_pkg::cfg_wr_t             cfg_i,
  input  logic                          accept_i,
  input  logic [c16d_pkg::ByteW-1:0]    rx_byte_i,
  output logic                          frame_ok_o,
  output c16d_pkg::payload_t            payload_o
);

  logic [c16d_pkg::ByteW-1:0]  header_q;
  logic [c16d_pkg::ByteW-1:0]  tail_q;
  c16d_pkg::window_t           window_q, window_d;
  logic [c16d_pkg::CountW-1:0] fresh_q, fresh_d, fresh_inc;
  logic                        crc_zero_q, crc_zero_d;
  logic                        match;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= c16d_pkg::HeaderReset;
      tail_q   <= c16d_pkg::TailReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        c16d_pkg::CFG_HEADER: header_q <= cfg_i.data;
        c16d_pkg::CFG_TAIL:   tail_q   <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // The window shifts toward index 0; the new byte enters at the top.
  always_comb begin
    for (int i = 0; i < c16d_pkg::WindowLen - 1; i++) begin
      window_d[i] = window_q[i+1];
    end
    window_d[c16d_pkg::WindowLen-1] = rx_byte_i;
  end

  // The CRC check is computed on the next window and registered beside it.
  assign crc_zero_d = c16d_pkg::window_crc_zero(window_d);

  assign fresh_inc = (fresh_q < c16d_pkg::FreshFull) ? fresh_q + 4'd1 : fresh_q;

  assign match = (fresh_inc == c16d_pkg::FreshFull) && (window_q[0] == header_q) &&
                 (rx_byte_i == tail_q) && crc_zero_q;

  assign frame_ok_o = accept_i && match;
  assign fresh_d    = match ? '0 : fresh_inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q   <= '0;
      fresh_q    <= '0;
      crc_zero_q <= c16d_pkg::window_crc_zero('0);
    end else if (accept_i) begin
      window_q   <= window_d;
      fresh_q    <= fresh_d;
      crc_zero_q <= crc_zero_d;
    end
  end

  assign payload_o.first  = window_q[2];
  assign payload_o.second = window_q[3];
  assign payload_o.third  = window_q[4];
  assign payload_o.fourth = window_q[5];

endmodule

// ----- rtl/c16d_queue.sv -----
// Result queue between the front end and the result port.
// Depends on c16d_pkg for the payload type.
`timescale 1ns / 1ps

module c16d_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_i,
  input  c16d_pkg::payload_t wr_data_i,
  input  logic               rd_i,
  output c16d_pkg::payload_t rd_data_o,
  output logic               full_o,
  output logic               empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  c16d_pkg::payload_t mem_q [Depth];
  logic [PtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]    count_q;
  logic               do_wr, do_rd;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + CntW'(1);
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

// ----- rtl/crc16_serial_deframer_top.sv -----
// Top level of the fixed-length serial deframer with Modbus CRC-16 check.
// A byte that completes a valid frame writes its payload into the result queue as it is taken.
// Throughput: one byte per cycle; input stalls only while ResultDepth results wait unread.
// Reset: asynchronous, active low; window and fresh count clear, header 0xDD, tail 0xED.
// Depends on c16d_pkg, c16d_front and c16d_queue.
`timescale 1ns / 1ps

module crc16_serial_deframer_top #(
  parameter int unsigned ResultDepth = 4
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Byte input, queue style: a transaction happens when push is high and full is low.
  input  logic                               push,
  output logic                               full,
  input  logic [c16d_pkg::ByteW-1:0]         rx_byte_i,
  // Result output: the oldest result is shown while empty is low; pop takes it.
  output logic                               empty,
  input  logic                               pop,
  output logic [c16d_pkg::ByteW-1:0]         payload_first_o,
  output logic [c16d_pkg::ByteW-1:0]         payload_second_o,
  output logic [c16d_pkg::ByteW-1:0]         payload_third_o,
  output logic [c16d_pkg::ByteW-1:0]         payload_fourth_o,
  // Configuration write channel; it never stalls.
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [c16d_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [c16d_pkg::ByteW-1:0]         cfg_data_i
);

  c16d_pkg::cfg_wr_t  cfg_wr;
  c16d_pkg::payload_t front_payload;
  c16d_pkg::payload_t queue_payload;
  logic               byte_accept;
  logic               frame_ok;

  // Configuration registers live in the front end. Writes to indexes past the
  // defined registers are dropped there.
  assign cfg_ready_o  = 1'b1;
  assign cfg_wr.valid = cfg_valid_i;
  assign cfg_wr.index = cfg_index_i;
  assign cfg_wr.data  = cfg_data_i;

  // A byte transaction is taken whenever the result queue has room, so a
  // frame found on this byte always has a slot to go into.
  assign byte_accept = push && !full;

  // Front end: holds the last eight bytes and the fresh count, and decides on
  // every accepted byte whether the nine-byte window forms a valid frame.
  c16d_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_wr),
    .accept_i   (byte_accept),
    .rx_byte_i  (rx_byte_i),
    .frame_ok_o (frame_ok),
    .payload_o  (front_payload)
  );

  // Back end: the result queue decouples frame detection from the consumer,
  // so input bytes keep flowing while earlier payloads wait to be popped.
  c16d_queue #(
    .Depth (ResultDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (frame_ok),
    .wr_data_i (front_payload),
    .rd_i      (pop),
    .rd_data_o (queue_payload),
    .full_o    (full),
    .empty_o   (empty)
  );

  assign payload_first_o  = queue_payload.first;
  assign payload_second_o = queue_payload.second;
  assign payload_third_o  = queue_payload.third;
  assign payload_fourth_o = queue_payload.fourth;

endmodule

// ----- dv/crc16_deframer_checker.sv -----
// Checker for the CRC-16 serial deframer: watches the byte, result and register
// channels, predicts each frame payload and compares it with what the block returns.
// Depends on c16d_pkg for widths, register codes, CRC constants and the payload type.
`timescale 1ns / 1ps

module crc16_deframer_checker
  import c16d_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  logic                 full_i,
  input  logic [ByteW-1:0]     rx_byte_i,
  input  logic                 empty_i,
  input  logic                 pop_i,
  input  logic [ByteW-1:0]     payload_first_i,
  input  logic [ByteW-1:0]     payload_second_i,
  input  logic [ByteW-1:0]     payload_third_i,
  input  logic [ByteW-1:0]     payload_fourth_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [ByteW-1:0]     cfg_data_i,
  output int                   fail_count_o,
  output int                   pending_o,
  output int                   bytes_o,
  output int                   payloads_o
);

  localparam int unsigned ShownMismatches = 10;

  logic [ByteW-1:0]  header_val;
  logic [ByteW-1:0]  tail_val;
  logic [ByteW-1:0]  recent [WindowLen];
  logic [CountW-1:0] fresh;
  payload_t          expected_payloads [$];
  payload_t          got;
  payload_t          want;

  // Reflected Modbus remainder over the eight held bytes, oldest first.
  function automatic logic [15:0] modbus_remainder(input logic [ByteW-1:0] w [WindowLen]);
    logic [15:0] rem;
    rem = CrcInit;
    for (int i = 0; i < WindowLen; i++) begin
      rem = rem ^ {8'h00, w[i]};
      for (int k = 0; k < ByteW; k++) begin
        rem = rem[0] ? ((rem >> 1) ^ CrcPoly) : (rem >> 1);
      end
    end
    return rem;
  endfunction

  task automatic take_byte(input logic [ByteW-1:0] rx);
    payload_t pl;
    if (fresh < FreshFull) begin
      fresh++;
    end
    if (fresh == FreshFull && recent[0] == header_val && rx == tail_val &&
        modbus_remainder(recent) == 16'h0000) begin
      pl.first  = recent[2];
      pl.second = recent[3];
      pl.third  = recent[4];
      pl.fourth = recent[5];
      expected_payloads.push_back(pl);
      fresh = '0;
    end
    for (int i = 0; i < WindowLen - 1; i++) begin
      recent[i] = recent[i + 1];
    end
    recent[WindowLen - 1] = rx;
  endtask

  task automatic note_mismatch(input string what, input payload_t e, input payload_t a);
    fail_count_o++;
    if (fail_count_o <= ShownMismatches) begin
      $display("%0t: %s: expected %02h %02h %02h %02h, got %02h %02h %02h %02h", $realtime,
               what, e.first, e.second, e.third, e.fourth, a.first, a.second, a.third, a.fourth);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_val = HeaderReset;
      tail_val   = TailReset;
      fresh      = '0;
      for (int i = 0; i < WindowLen; i++) begin
        recent[i] = '0;
      end
      expected_payloads.delete();
      fail_count_o = 0;
      pending_o    = 0;
      bytes_o      = 0;
      payloads_o   = 0;
    end else begin
      // Results are checked before the byte of this edge is predicted: a byte
      // taken now cannot have produced the result that leaves now.
      if (pop_i && !empty_i) begin
        got.first  = payload_first_i;
        got.second = payload_second_i;
        got.third  = payload_third_i;
        got.fourth = payload_fourth_i;
        payloads_o++;
        if (expected_payloads.size() == 0) begin
          note_mismatch("result with no frame behind it", '0, got);
        end else begin
          want = expected_payloads.pop_front();
          if (want != got) begin
            note_mismatch("payload mismatch", want, got);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_HEADER: header_val = cfg_data_i;
          CFG_TAIL:   tail_val   = cfg_data_i;
          default: ;
        endcase
      end
      if (push_i && !full_i) begin
        take_byte(rx_byte_i);
        bytes_o++;
      end
      pending_o = expected_payloads.size();
    end
  end

endmodule

// ----- dv/tb.sv -----
// Testbench top for the CRC-16 serial deframer: clock, reset, byte stream, register
// writes, result stalls and the verdict. Depends on c16d_pkg, crc16_serial_deframer_top
// and crc16_deframer_checker, which does all prediction and comparison.
`timescale 1ns / 1ps

module tb;
  import c16d_pkg::*;

  localparam time         ClkPeriod  = 8ns;
  localparam int unsigned ResetCycles = 7;
  localparam int unsigned Phases      = 8;
  localparam int unsigned PhaseBytes  = 150;
  // The block queues a payload as its closing byte is taken, so this short quiet
  // pause is plenty before a register write or the verdict.
  localparam int unsigned SettleCycles = 4;
  // Longest honest quiet stretch: the longest receiver hold, the longest sender
  // gap and the settle pause. The limit takes that many times over.
  localparam int unsigned IdleLimit = 1000;

  // Register indexes that the block does not implement; writes there are dropped.
  localparam logic [CfgIdxW-1:0] CfgSpareLo = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareHi = 2'd3;

  // Ways a frame is put on the wire: intact, with one flipped bit, or with its
  // header byte left off so that the preceding byte has to stand in for it.
  typedef enum logic [1:0] {
    FRAME_GOOD,
    FRAME_CORRUPT,
    FRAME_CLIPPED
  } frame_kind_e;

  // Receiver behavior: always ready, coin-flip ready, or long holds.
  typedef enum logic [1:0] {
    POP_ALWAYS,
    POP_COIN,
    POP_HOLDS
  } pop_mode_e;

  logic             clk_i        = 1'b0;
  logic             rst_ni       = 1'b0;
  logic             push         = 1'b0;
  logic             full;
  logic [ByteW-1:0] rx_byte      = '0;
  logic             empty;
  logic             pop          = 1'b0;
  logic [ByteW-1:0] payload_first;
  logic [ByteW-1:0] payload_second;
  logic [ByteW-1:0] payload_third;
  logic [ByteW-1:0] payload_fourth;
  logic             cfg_valid    = 1'b0;
  logic             cfg_ready;
  logic [CfgIdxW-1:0] cfg_index  = '0;
  logic [ByteW-1:0] cfg_data     = '0;

  int        fail_count;
  int        pending;
  int        bytes_taken;
  int        payloads_seen;

  int        sent_bytes   = 0;
  int        burst_left   = 0;
  bit        gaps_on      = 1'b1;
  pop_mode_e pop_mode     = POP_ALWAYS;
  int        hold_left    = 0;
  int        idle_cycles  = 0;
  int        settings_run = 0;

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  crc16_serial_deframer_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .rx_byte_i        (rx_byte),
    .empty            (empty),
    .pop              (pop),
    .payload_first_o  (payload_first),
    .payload_second_o (payload_second),
    .payload_third_o  (payload_third),
    .payload_fourth_o (payload_fourth),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data)
  );

  crc16_deframer_checker chk (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push_i           (push),
    .full_i           (full),
    .rx_byte_i        (rx_byte),
    .empty_i          (empty),
    .pop_i            (pop),
    .payload_first_i  (payload_first),
    .payload_second_i (payload_second),
    .payload_third_i  (payload_third),
    .payload_fourth_i (payload_fourth),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .bytes_o          (bytes_taken),
    .payloads_o       (payloads_seen)
  );

  // The receiver changes its mind at the falling edge only. In hold mode it now
  // and then refuses results for a long stretch, which fills the result queue
  // and pushes back on the byte input through full.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      pop <= 1'b0;
      hold_left--;
    end else begin
      case (pop_mode)
        POP_ALWAYS: pop <= 1'b1;
        POP_COIN:   pop <= 1'($urandom_range(0, 1));
        default: begin
          if ($urandom_range(0, 15) == 0) begin
            hold_left = $urandom_range(5, 40);
            pop <= 1'b0;
          end else begin
            pop <= 1'b1;
          end
        end
      endcase
    end
  end

  // Watchdog: any transaction on any channel counts as progress. A run that stops
  // moving until the idle count reaches IdleLimit is a hang and ends as a failure.
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("watchdog: no transaction for %0d cycles", IdleLimit);
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Mostly random bytes, with the all-zeros and all-ones values kept frequent.
  function automatic logic [ByteW-1:0] pick_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Modbus CRC over the six bytes ahead of the CRC field: header, length, payload.
  function automatic logic [15:0] frame_crc(input logic [ByteW-1:0] fb [FrameBytes]);
    logic [15:0] crc;
    crc = CrcInit;
    for (int i = 0; i < 6; i++) begin
      crc = crc ^ {8'h00, fb[i]};
      repeat (ByteW) begin
        crc = crc[0] ? ((crc >> 1) ^ CrcPoly) : (crc >> 1);
      end
    end
    return crc;
  endfunction

  // One byte transaction. The sender runs in bursts; at the end of a burst it
  // drops push for a random gap before the next byte, unless gaps are off.
  task automatic send_byte(input logic [ByteW-1:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = 0;
      if (gaps_on) begin
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : $urandom_range(0, 2);
      end
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        @(negedge clk_i);
        push <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    @(negedge clk_i);
    push    <= 1'b1;
    rx_byte <= b;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    burst_left--;
    sent_bytes++;
  endtask

  // Builds a nine-byte frame (header, length, four payload bytes, CRC low and
  // high, tail) and sends it in the requested shape.
  task automatic send_frame(input frame_kind_e kind, input logic [ByteW-1:0] hdr,
                            input logic [ByteW-1:0] tl, input logic [ByteW-1:0] len,
                            input payload_t pl);
    logic [ByteW-1:0] fb [FrameBytes];
    logic [15:0]      crc;
    int               pos;
    int               start;
    fb[0] = hdr;
    fb[1] = len;
    fb[2] = pl.first;
    fb[3] = pl.second;
    fb[4] = pl.third;
    fb[5] = pl.fourth;
    crc   = frame_crc(fb);
    fb[6] = crc[7:0];
    fb[7] = crc[15:8];
    fb[8] = tl;
    if (kind == FRAME_CORRUPT) begin
      pos     = $urandom_range(0, FrameBytes - 1);
      fb[pos] = fb[pos] ^ (8'h01 << $urandom_range(0, ByteW - 1));
    end
    start = (kind == FRAME_CLIPPED) ? 1 : 0;
    for (int i = start; i < FrameBytes; i++) begin
      send_byte(fb[i]);
    end
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [ByteW-1:0] data);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // Stop sending, let every predicted payload come back, then give the block the
  // settle pause in case the last byte is still being weighed as a frame end.
  task automatic drain();
    @(negedge clk_i);
    push <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic set_framing(input logic [ByteW-1:0] hdr, input logic [ByteW-1:0] tl,
                             input logic [CfgIdxW-1:0] spare);
    cfg_write(CFG_HEADER, hdr);
    cfg_write(spare, pick_byte());
    cfg_write(CFG_TAIL, tl);
    settings_run++;
  endtask

  initial begin
    logic [ByteW-1:0] hdr;
    logic [ByteW-1:0] tl;
    payload_t         pl;
    int               target;
    int               pick;

    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part. Header 0x00 and tail 0xFF are the extremes of both
    // registers. A zero header also matches the cleared window, so a clipped
    // frame sent first would pass the header and CRC tests; only the count of
    // fresh bytes since reset keeps it from being taken.
    hdr = 8'h00;
    tl  = 8'hFF;
    set_framing(hdr, tl, CfgSpareLo);
    pl = '{first: 8'h00, second: 8'hFF, third: 8'h00, fourth: 8'hFF};
    send_frame(FRAME_CLIPPED, hdr, tl, 8'h5A, pl);
    // A clean frame with an all-ones length byte, which the block must ignore.
    send_frame(FRAME_GOOD, hdr, tl, 8'hFF, pl);
    // A damaged frame right after it: no payload may come out.
    pl = '{first: 8'hFF, second: 8'h00, third: 8'hFF, fourth: 8'h00};
    send_frame(FRAME_CORRUPT, hdr, tl, 8'h00, pl);
    drain();

    // Random part: one register setting per phase, each with its own sender
    // and receiver behavior so that stalls land on every part of a frame.
    for (int p = 0; p < Phases; p++) begin
      case (p)
        0: begin
          hdr = HeaderReset;
          tl  = TailReset;
        end
        1: begin
          hdr = 8'hFF;
          tl  = 8'h00;
        end
        default: begin
          hdr = pick_byte();
          // Equal header and tail let a clipped frame borrow the tail of the
          // frame before it, which must still be refused as reused bytes.
          tl  = ($urandom_range(0, 2) == 0) ? hdr : pick_byte();
        end
      endcase
      pop_mode = pop_mode_e'(p % 3);
      gaps_on  = (p % 4) != 3;
      set_framing(hdr, tl, (p % 2 == 0) ? CfgSpareHi : CfgSpareLo);

      target = sent_bytes + PhaseBytes;
      while (sent_bytes < target) begin
        pl.first  = pick_byte();
        pl.second = pick_byte();
        pl.third  = pick_byte();
        pl.fourth = pick_byte();
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
          send_frame(FRAME_GOOD, hdr, tl, pick_byte(), pl);
        end else if (pick < 75) begin
          send_frame(FRAME_CORRUPT, hdr, tl, pick_byte(), pl);
        end else if (pick < 83) begin
          send_frame(FRAME_CLIPPED, hdr, tl, pick_byte(), pl);
        end else if (pick < 88) begin
          // Runs of framing bytes tempt the block into false frame starts.
          repeat ($urandom_range(1, 4)) send_byte($urandom_range(0, 1) ? hdr : tl);
        end else begin
          repeat ($urandom_range(1, 6)) send_byte(pick_byte());
        end
      end
      drain();
    end

    $display("Run covered %0d bytes under %0d register settings; %0d payloads compared.",
             bytes_taken, settings_run, payloads_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
